>>> rtl/mpe_pkg.sv
// ----------------------------------------------------------------------------
// mpe_pkg
// Types and codes shared by the matrix polynomial evaluator.
// ----------------------------------------------------------------------------
package mpe_pkg;

  typedef enum logic [1:0] {
    REQ_LOAD_MAT  = 2'd0,
    REQ_LOAD_COEF = 2'd1,
    REQ_EVAL      = 2'd2
  } req_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_MAC,
    ST_DRAIN,
    ST_SMUL,
    ST_SACC,
    ST_OUT
  } state_e;

  localparam logic       CFG_DIM    = 1'b0;
  localparam logic       CFG_DEGREE = 1'b1;

  localparam logic [3:0] DIM_RESET    = 4'd8;
  localparam logic [3:0] DEGREE_RESET = 4'd0;

endpackage

>>> rtl/matrix_polynomial_evaluator.sv
// ----------------------------------------------------------------------------
// matrix_polynomial_evaluator
// Computes c0*I + c1*A + ... + cn*A^n over 32-bit wrapping integers.
// ----------------------------------------------------------------------------
// A load word (matrix element or coefficient) does not raise busy, so loads
// can follow each other back to back. An evaluate word keeps busy high while
// the identity power and the c0 diagonal are set up, while each power step,
// up to the clamped degree, runs every element of the clamped dim by dim
// product through the single multiply-accumulate unit, which reads one power
// element and one matrix element per cycle from their memories while a dot
// product is issued, and while the result is then read out of the sum memory
// one element per cycle. Result words appear on out_valid_o one per cycle in
// row-major order, the final one in the first cycle with busy low; the
// receiver cannot stall them.
module matrix_polynomial_evaluator
  import mpe_pkg::*;
#(
  parameter int MAX_DIM    = 8,
  parameter int MAX_DEGREE = 15
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         req_type_i,
  input  logic [2:0]         row_i,
  input  logic [2:0]         col_i,
  input  logic [3:0]         coef_index_i,
  input  logic signed [31:0] value_i,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [3:0]         cfg_data_i,
  output logic               out_valid_o,
  output logic [2:0]         out_row_o,
  output logic [2:0]         out_col_o,
  output logic signed [31:0] result_o,
  output logic               last_o
);

  localparam int CELLS    = MAX_DIM * MAX_DIM;
  localparam int IDX_W    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int CELL_W   = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int DEG_W    = $clog2(MAX_DEGREE + 1);
  localparam int PW_DEPTH = 2 * (2 ** CELL_W);

  function automatic logic [CELL_W-1:0] cell_addr(input logic [IDX_W-1:0] r,
                                                  input logic [IDX_W-1:0] c);
    cell_addr = CELL_W'(int'(r) * MAX_DIM + int'(c));
  endfunction

  // Configuration registers.
  logic [3:0] dim_q, degree_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_q    <= DIM_RESET;
      degree_q <= DEGREE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DIM:    dim_q    <= cfg_data_i;
        CFG_DEGREE: degree_q <= cfg_data_i;
        default:    ;
      endcase
    end
  end

  // Control state.
  state_e             state_q, state_d;
  logic [IDX_W-1:0]   i_q, j_q, k_q, dm1_q;
  logic [DEG_W-1:0]   p_q, n_q;
  logic               bank_q;
  logic               rd_vld_q, rd_first_q, rd_last_q;
  logic               mul_vld_q, mul_first_q, mul_last_q;
  logic               out_vld_q, out_last_q;

  // Payload registers.
  logic [31:0]        prod_q, acc_q, v_q, cprod_q;
  logic [2:0]         out_row_q, out_col_q;

  logic               accept, is_eval, last_cell, k_last, mac_final, issue;
  logic [31:0]        mac_sum;
  logic [IDX_W-1:0]   dm1_d;
  logic [DEG_W-1:0]   n_d;

  // Memory ports.
  logic               mat_we, coef_we, pow_we, sum_we;
  logic               pow_re, mat_re, sum_re;
  logic [CELL_W-1:0]  mat_waddr, mat_raddr, sum_addr;
  logic [DEG_W-1:0]   coef_waddr, coef_raddr;
  logic [CELL_W:0]    pow_waddr, pow_raddr;
  logic [31:0]        pow_wdata, sum_wdata;
  logic [31:0]        mat_rdata, coef_rdata, pow_rdata, sum_rdata;

  assign busy      = (state_q != ST_IDLE);
  assign accept    = start && !busy;
  assign is_eval   = (req_type_i == REQ_EVAL);
  assign last_cell = (i_q == dm1_q) && (j_q == dm1_q);
  assign k_last    = (k_q == dm1_q);
  assign mac_final = mul_vld_q && mul_last_q;
  assign mac_sum   = (mul_first_q ? 32'd0 : acc_q) + prod_q;

  // Clamp dim and degree into the supported range when an evaluation starts.
  always_comb begin
    if (dim_q == 4'd0) begin
      dm1_d = '0;
    end else if (5'(dim_q) > 5'(MAX_DIM)) begin
      dm1_d = IDX_W'(MAX_DIM - 1);
    end else begin
      dm1_d = IDX_W'(dim_q - 4'd1);
    end
    if (6'(degree_q) > 6'(MAX_DEGREE)) begin
      n_d = DEG_W'(MAX_DEGREE);
    end else begin
      n_d = DEG_W'(degree_q);
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && is_eval) state_d = ST_INIT;
      end
      ST_INIT: begin
        if (last_cell) state_d = (n_q == '0) ? ST_OUT : ST_MAC;
      end
      ST_MAC: begin
        if (k_last) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (mac_final) state_d = ST_SMUL;
      end
      ST_SMUL: begin
        state_d = ST_SACC;
      end
      ST_SACC: begin
        if (last_cell && (p_q == n_q)) state_d = ST_OUT;
        else                           state_d = ST_MAC;
      end
      ST_OUT: begin
        if (last_cell) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Memory controls.
  always_comb begin
    issue      = 1'b0;
    mat_we     = 1'b0;
    coef_we    = 1'b0;
    pow_we     = 1'b0;
    sum_we     = 1'b0;
    sum_re     = 1'b0;
    mat_waddr  = cell_addr(IDX_W'(row_i), IDX_W'(col_i));
    coef_waddr = DEG_W'(coef_index_i);
    coef_raddr = p_q;
    pow_waddr  = {bank_q, cell_addr(i_q, j_q)};
    pow_wdata  = (i_q == j_q) ? 32'd1 : 32'd0;
    sum_wdata  = (i_q == j_q) ? coef_rdata : 32'd0;
    case (state_q)
      ST_IDLE: begin
        coef_raddr = '0;
        if (accept) begin
          case (req_type_i)
            REQ_LOAD_MAT: begin
              mat_we = (5'(row_i) < 5'(MAX_DIM)) && (5'(col_i) < 5'(MAX_DIM));
            end
            REQ_LOAD_COEF: begin
              coef_we = (6'(coef_index_i) <= 6'(MAX_DEGREE));
            end
            default: ;
          endcase
        end
      end
      ST_INIT: begin
        coef_raddr = '0;
        pow_we     = 1'b1;
        sum_we     = 1'b1;
      end
      ST_MAC: begin
        issue = 1'b1;
      end
      ST_DRAIN: begin
        // The finished dot product goes to the other power bank, and the
        // running sum of this element is fetched for the update.
        pow_we    = mac_final;
        pow_waddr = {!bank_q, cell_addr(i_q, j_q)};
        pow_wdata = mac_sum;
        sum_re    = mac_final;
      end
      ST_SMUL: ;
      ST_SACC: begin
        sum_we    = 1'b1;
        sum_wdata = sum_rdata + cprod_q;
      end
      ST_OUT: begin
        sum_re = 1'b1;
      end
      default: ;
    endcase
  end

  assign mat_re    = issue;
  assign pow_re    = issue;
  assign mat_raddr = cell_addr(k_q, j_q);
  assign pow_raddr = {bank_q, cell_addr(i_q, k_q)};
  assign sum_addr  = cell_addr(i_q, j_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      dm1_q       <= '0;
      p_q         <= '0;
      n_q         <= '0;
      bank_q      <= 1'b0;
      rd_vld_q    <= 1'b0;
      rd_first_q  <= 1'b0;
      rd_last_q   <= 1'b0;
      mul_vld_q   <= 1'b0;
      mul_first_q <= 1'b0;
      mul_last_q  <= 1'b0;
      out_vld_q   <= 1'b0;
      out_last_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      rd_vld_q    <= issue;
      rd_first_q  <= (k_q == '0);
      rd_last_q   <= k_last;
      mul_vld_q   <= rd_vld_q;
      mul_first_q <= rd_first_q;
      mul_last_q  <= rd_last_q;
      out_vld_q   <= (state_q == ST_OUT);
      out_last_q  <= last_cell;

      if (state_q == ST_IDLE && accept && is_eval) begin
        dm1_q <= dm1_d;
        n_q   <= n_d;
        i_q   <= '0;
        j_q   <= '0;
        k_q   <= '0;
      end

      if (state_q == ST_MAC) begin
        k_q <= k_last ? '0 : k_q + 1'b1;
      end

      if (state_q == ST_INIT || state_q == ST_SACC || state_q == ST_OUT) begin
        if (j_q == dm1_q) begin
          j_q <= '0;
          i_q <= (i_q == dm1_q) ? '0 : i_q + 1'b1;
        end else begin
          j_q <= j_q + 1'b1;
        end
      end

      if (state_q == ST_INIT && last_cell) begin
        p_q <= DEG_W'(1);
      end

      if (state_q == ST_SACC && last_cell) begin
        bank_q <= !bank_q;
        if (p_q != n_q) p_q <= p_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= pow_rdata * mat_rdata;
    if (mul_vld_q) acc_q <= mac_sum;
    if (state_q == ST_DRAIN && mac_final) v_q <= mac_sum;
    cprod_q <= coef_rdata * v_q;
    if (state_q == ST_OUT) begin
      out_row_q <= 3'(i_q);
      out_col_q <= 3'(j_q);
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_row_o   = out_row_q;
  assign out_col_o   = out_col_q;
  assign result_o    = $signed(sum_rdata);
  assign last_o      = out_vld_q && out_last_q;

  mpe_ram #(.WIDTH(32), .DEPTH(CELLS)) u_mat_ram (
    .clk_i   (clk_i),
    .we_i    (mat_we),
    .waddr_i (mat_waddr),
    .wdata_i ($unsigned(value_i)),
    .re_i    (mat_re),
    .raddr_i (mat_raddr),
    .rdata_o (mat_rdata)
  );

  mpe_ram #(.WIDTH(32), .DEPTH(MAX_DEGREE + 1)) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (coef_we),
    .waddr_i (coef_waddr),
    .wdata_i ($unsigned(value_i)),
    .re_i    (1'b1),
    .raddr_i (coef_raddr),
    .rdata_o (coef_rdata)
  );

  // Two banks: one holds the current power, the other takes the next one.
  mpe_ram #(.WIDTH(32), .DEPTH(PW_DEPTH)) u_pow_ram (
    .clk_i   (clk_i),
    .we_i    (pow_we),
    .waddr_i (pow_waddr),
    .wdata_i (pow_wdata),
    .re_i    (pow_re),
    .raddr_i (pow_raddr),
    .rdata_o (pow_rdata)
  );

  mpe_ram #(.WIDTH(32), .DEPTH(CELLS)) u_sum_ram (
    .clk_i   (clk_i),
    .we_i    (sum_we),
    .waddr_i (sum_addr),
    .wdata_i (sum_wdata),
    .re_i    (sum_re),
    .raddr_i (sum_addr),
    .rdata_o (sum_rdata)
  );

`ifndef ASSERT_OFF
  a_out_from_readout: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $past(state_q == ST_OUT))
    else $error("result word without a readout cycle");

  a_load_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mat_we || coef_we) |-> (state_q == ST_IDLE))
    else $error("load write outside idle");

  a_drained_before_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SMUL) |-> (!rd_vld_q && !mul_vld_q))
    else $error("sum update while products are in flight");

  a_last_ends_matrix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_o |=> !out_valid_o)
    else $error("result word after the last one");

  a_k_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue |-> (k_q <= dm1_q))
    else $error("inner index beyond dim");
`endif

endmodule

>>> rtl/mpe_ram.sv
// ----------------------------------------------------------------------------
// mpe_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read that holds its data while the read enable is low.
// ----------------------------------------------------------------------------
module mpe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
